/* hdl/assert_macros.svh */
// concurrent assertion helpers, clock and active-low reset passed in
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mrc_pkg.sv */
package mrc_pkg;

  localparam int unsigned REGISTER_COUNT_DEF = 12;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd81;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_ADDR  = 3'd1,
    STAT_FUNC  = 3'd2,
    STAT_COUNT = 3'd3,
    STAT_CRC   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

/* hdl/mrc_in_if.sv */
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

/* hdl/mrc_out_if.sv */
interface mrc_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  reg_index;
  logic signed [15:0] reg_value;
  logic        [2:0]  status;
  logic               last;

  modport source (output valid, output reg_index, output reg_value, output status,
                  output last, input ready);
  modport sink (input valid, input reg_index, input reg_value, input status,
                input last, output ready);
endinterface

/* hdl/mrc_cfg_if.sv */
interface mrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/modbus_read_response_checker_core.sv */
// channel  | dir | beat
// in_i     | in  | one response byte, frame_start marks the first
// cfg_i    | in  | expected slave address, always ready
// out_o    | out | one register result, status of the frame, last flag
//
// ignored bytes and the trailer-low byte leave the sequencer idle; address, function, count
// and data bytes wait in S_CRC, the crc advancing one bit per cycle in the serial crc unit.
// the final byte starts a store read then an output load for each register in turn,
// ending idle after the last register.
// reset leaves the block idle: bytes without frame_start are ignored.
// a stall on out_o holds the sequencer; the last result may still wait while
// the next byte is taken.
`include "assert_macros.svh"

module modbus_read_response_checker_core #(
  parameter int unsigned REGISTER_COUNT = mrc_pkg::REGISTER_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrc_in_if.sink    in_i,
  mrc_cfg_if.sink   cfg_i,
  mrc_out_if.source out_o
);
  import mrc_pkg::*;

  localparam int unsigned FrameBytes = 2 * REGISTER_COUNT + 5;
  localparam int unsigned DataEnd    = 2 * REGISTER_COUNT + 3;
  localparam int unsigned PosW       = $clog2(FrameBytes + 1);
  localparam int unsigned IdxW       = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [7:0]  ByteCount  = 8'((2 * REGISTER_COUNT) % 256);
  localparam logic [IdxW-1:0] RdLast = IdxW'(REGISTER_COUNT - 1);

  state_e state_q, state_d;

  logic [7:0]      slave_addr_q;
  logic [PosW-1:0] pos_q, pos_d;
  status_e         hdr_status_q, hdr_status_d;
  status_e         frame_status_q, frame_status_d;
  logic [7:0]      held_q, held_d;
  logic [7:0]      trailer_q, trailer_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic               out_valid_q, out_valid_d;
  logic [IdxW+3:0]    out_idx_q, out_idx_d;
  logic signed [15:0] out_value_q, out_value_d;
  status_e            out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  // byte decode
  logic            in_acc, frame_live, is_crc_byte, is_final;
  logic [PosW-1:0] pos_eff, off;
  status_e         hdr_base;

  crc_cmd_t    crc_cmd;
  logic [15:0] crc_val;
  logic        crc_busy;

  logic            wr_en, rd_en, load_en;
  logic [IdxW-1:0] wr_addr;
  logic [15:0]     rd_data;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign in_acc      = in_i.valid && in_i.ready;
  assign pos_eff     = in_i.frame_start ? '0 : pos_q;
  assign frame_live  = in_i.frame_start || (pos_q < PosW'(FrameBytes));
  assign is_crc_byte = frame_live && (pos_eff < PosW'(DataEnd));
  assign is_final    = frame_live && (pos_eff == PosW'(DataEnd + 1));
  assign hdr_base    = in_i.frame_start ? STAT_OK : hdr_status_q;
  assign off         = pos_eff - PosW'(3);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && is_crc_byte) begin
          state_d = S_CRC;
        end else if (in_acc && is_final) begin
          state_d = S_READ;
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_d = S_IDLE;
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (load_en) begin
          state_d = (rd_idx_q == RdLast) ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    crc_cmd.load    = in_acc && is_crc_byte;
    crc_cmd.restart = in_i.frame_start;
    crc_cmd.data    = in_i.data_byte;
    rd_en           = (state_q == S_READ);
    load_en         = (state_q == S_LOAD) && (!out_valid_q || out_o.ready);
    wr_en           = in_acc && is_crc_byte && (pos_eff > PosW'(2)) && off[0];
    wr_addr         = off[IdxW:1];
  end

  // frame datapath
  always_comb begin
    pos_d          = pos_q;
    hdr_status_d   = hdr_status_q;
    frame_status_d = frame_status_q;
    held_d         = held_q;
    trailer_d      = trailer_q;
    rd_idx_d       = rd_idx_q;
    if (in_acc && frame_live) begin
      pos_d        = pos_eff + 1'b1;
      hdr_status_d = hdr_base;
      if (pos_eff == PosW'(0)) begin
        if (in_i.data_byte != slave_addr_q) begin
          hdr_status_d = STAT_ADDR;
        end
      end else if (pos_eff == PosW'(1)) begin
        if (hdr_base == STAT_OK && in_i.data_byte != FUNC_READ_HOLD) begin
          hdr_status_d = STAT_FUNC;
        end
      end else if (pos_eff == PosW'(2)) begin
        if (hdr_base == STAT_OK && in_i.data_byte != ByteCount) begin
          hdr_status_d = STAT_COUNT;
        end
      end else if (pos_eff < PosW'(DataEnd)) begin
        if (!off[0]) begin
          held_d = in_i.data_byte;
        end
      end else if (pos_eff == PosW'(DataEnd)) begin
        trailer_d = in_i.data_byte;
      end else begin
        frame_status_d = hdr_base;
        if (hdr_base == STAT_OK && crc_val != {in_i.data_byte, trailer_q}) begin
          frame_status_d = STAT_CRC;
        end
        rd_idx_d = '0;
      end
    end
    if (load_en && rd_idx_q != RdLast) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_en) begin
      out_valid_d  = 1'b1;
      out_idx_d    = {4'b0000, rd_idx_q};
      out_value_d  = $signed(rd_data);
      out_status_d = frame_status_q;
      out_last_d   = (rd_idx_q == RdLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slave_addr_q   <= SLAVE_ADDR_RST;
      pos_q          <= PosW'(FrameBytes);
      hdr_status_q   <= STAT_OK;
      frame_status_q <= STAT_OK;
      held_q         <= '0;
      trailer_q      <= '0;
      rd_idx_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      pos_q          <= pos_d;
      hdr_status_q   <= hdr_status_d;
      frame_status_q <= frame_status_d;
      held_q         <= held_d;
      trailer_q      <= trailer_d;
      rd_idx_q       <= rd_idx_d;
      out_valid_q    <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        slave_addr_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q    <= out_idx_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.reg_index = out_idx_q[3:0];
  assign out_o.reg_value = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

  mrc_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .crc_o  (crc_val),
    .busy_o (crc_busy)
  );

  mrc_reg_store #(
    .Depth (REGISTER_COUNT),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({held_q, in_i.data_byte}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  `ASSERT_IMP(a_no_byte_while_crc, clk_i, rst_ni, crc_busy, !in_i.ready, "byte taken while crc busy")
  `ASSERT_NXT(a_read_then_load, clk_i, rst_ni, state_q == S_READ, state_q == S_LOAD, "store read not followed by load")
  `ASSERT_NXT(a_last_ends_burst, clk_i, rst_ni, load_en && (rd_idx_q == RdLast), (state_q == S_IDLE) && out_o.valid && out_o.last, "final result did not end the burst")

endmodule

/* hdl/mrc_crc_serial.sv */
module mrc_crc_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrc_pkg::crc_cmd_t cmd_i,
  output logic [15:0]      crc_o,
  output logic             busy_o
);
  import mrc_pkg::*;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CntW        = $clog2(BitsPerByte);

  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [15:0]     base;

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    base   = cmd_i.restart ? CRC_INIT : crc_q;
    if (cmd_i.load) begin
      crc_d  = base ^ {8'h00, cmd_i.data};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one polynomial step per cycle, lsb first
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BitsPerByte - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = busy_q;

endmodule

/* hdl/mrc_reg_store.sv */
module mrc_reg_store #(
  parameter int unsigned Depth = mrc_pkg::REGISTER_COUNT_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [15:0]      wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [15:0]      rd_data_o
);
  import mrc_pkg::*;

  logic [15:0] mem [Depth];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
